// ===== hdl/stereo_mean_level_bar_meter_defines.svh =====
`ifndef STEREO_MEAN_LEVEL_BAR_METER_DEFINES_SVH
`define STEREO_MEAN_LEVEL_BAR_METER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SMLB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SMLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/smlb_pkg.sv =====
`timescale 1ns / 1ps
package smlb_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int MAG_W       = 26;
  localparam int SUM_W       = COUNT_WIDTH + MAG_W;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int SHIFT_BITS  = 6;
  localparam int NUM_SEG     = 11;
  localparam int BAR_W       = 4;
  localparam int WORD_W      = 32;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;
  localparam logic HALF_FIRST = 1'b0;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [MAG_W-1:0]       mag_t;
  typedef logic [BAR_W-1:0]       bar_t;

  localparam mag_t SEG_THRESH [NUM_SEG] = '{
    mag_t'(734000),  mag_t'(2350000), mag_t'(3350000), mag_t'(4250000),
    mag_t'(5250000), mag_t'(6000000), mag_t'(6800000), mag_t'(7500000),
    mag_t'(8500000), mag_t'(9500000), mag_t'(10800000)
  };

  // classified item handed from front to back
  typedef struct packed {
    logic kind;
    logic half;
    logic active;
    mag_t left_mag;
    mag_t right_mag;
  } qitem_t;

  // |word >>> 6|, at most 2^25
  function automatic mag_t shifted_mag(input logic [WORD_W-1:0] word);
    logic signed [WORD_W-1:0] sh;
    logic [WORD_W-1:0]        neg;
    sh  = $signed(word) >>> SHIFT_BITS;
    neg = WORD_W'(-sh);
    return sh[WORD_W-1] ? neg[MAG_W-1:0] : sh[MAG_W-1:0];
  endfunction

  // thermometer segment count
  function automatic bar_t bar_of(input mag_t mean);
    bar_t n;
    n = '0;
    for (int i = 0; i < NUM_SEG; i++) begin
      if (mean >= SEG_THRESH[i]) begin
        n = n + bar_t'(1);
      end
    end
    return n;
  endfunction

endpackage

// ===== hdl/smlb_front.sv =====
`timescale 1ns / 1ps
module smlb_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [smlb_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  input  logic                                q_full,
  output logic                                q_push,
  output smlb_pkg::qitem_t                    q_item
);

  smlb_pkg::mag_t lmag;
  smlb_pkg::mag_t rmag;

  always_comb begin
    lmag = smlb_pkg::shifted_mag(in_tdata[smlb_pkg::WORD_W-1:0]);
    rmag = smlb_pkg::shifted_mag(in_tdata[2*smlb_pkg::WORD_W-1:smlb_pkg::WORD_W]);
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.kind      = in_tuser;
    q_item.half      = in_tdata[2*smlb_pkg::WORD_W];
    q_item.active    = (lmag != '0) || (rmag != '0);
    q_item.left_mag  = lmag;
    q_item.right_mag = rmag;
  end

endmodule

// ===== hdl/smlb_queue.sv =====
`timescale 1ns / 1ps
module smlb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  smlb_pkg::qitem_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output smlb_pkg::qitem_t q_item
);

  smlb_pkg::qitem_t                 mem_r [smlb_pkg::QUEUE_DEPTH];
  logic [smlb_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [smlb_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [smlb_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             do_pop;

  assign full    = (cnt_r == smlb_pkg::QCNT_W'(smlb_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == smlb_pkg::QPTR_W'(smlb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + smlb_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == smlb_pkg::QPTR_W'(smlb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + smlb_pkg::QPTR_W'(1);
    end
    unique if (push && !do_pop) begin
      cnt_nxt = cnt_r + smlb_pkg::QCNT_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - smlb_pkg::QCNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/smlb_back.sv =====
`timescale 1ns / 1ps
`include "stereo_mean_level_bar_meter_defines.svh"
module smlb_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  smlb_pkg::qitem_t      q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_report,
  output smlb_pkg::mag_t        out_lmean,
  output smlb_pkg::mag_t        out_rmean,
  output smlb_pkg::bar_t        out_bar,
  output logic                  out_led
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  localparam int CW = smlb_pkg::COUNT_WIDTH;
  localparam int SW = smlb_pkg::SUM_W;

  state_t                        state_r, state_nxt;
  smlb_pkg::sum_t                lsum_r, lsum_nxt;
  smlb_pkg::sum_t                rsum_r, rsum_nxt;
  smlb_pkg::count_t              cnt_r, cnt_nxt;
  logic                          act_r, act_nxt;

  // divider: dividend shifts out the top while quotient bits shift in
  smlb_pkg::sum_t                lq_r, lq_nxt;
  smlb_pkg::sum_t                rq_r, rq_nxt;
  smlb_pkg::count_t              lrem_r, lrem_nxt;
  smlb_pkg::count_t              rrem_r, rrem_nxt;
  smlb_pkg::count_t              dvs_r, dvs_nxt;
  logic [smlb_pkg::STEP_W-1:0]   step_r, step_nxt;

  logic                          oval_r, oval_nxt;
  logic                          orep_r, orep_nxt;
  smlb_pkg::mag_t                olm_r, olm_nxt;
  smlb_pkg::mag_t                orm_r, orm_nxt;
  smlb_pkg::bar_t                obar_r, obar_nxt;
  logic                          oled_r, oled_nxt;

  logic                          slot_free;
  logic [CW:0]                   ltrial, rtrial;
  logic                          lge, rge;
  smlb_pkg::count_t              lrem_step, rrem_step;

  always_comb begin
    ltrial    = {lrem_r, lq_r[SW-1]};
    rtrial    = {rrem_r, rq_r[SW-1]};
    lge       = ltrial >= {1'b0, dvs_r};
    rge       = rtrial >= {1'b0, dvs_r};
    lrem_step = lge ? CW'(ltrial - {1'b0, dvs_r}) : ltrial[CW-1:0];
    rrem_step = rge ? CW'(rtrial - {1'b0, dvs_r}) : rtrial[CW-1:0];
  end

  assign slot_free = !oval_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    lsum_nxt  = lsum_r;
    rsum_nxt  = rsum_r;
    cnt_nxt   = cnt_r;
    act_nxt   = act_r;
    lq_nxt    = lq_r;
    rq_nxt    = rq_r;
    lrem_nxt  = lrem_r;
    rrem_nxt  = rrem_r;
    dvs_nxt   = dvs_r;
    step_nxt  = step_r;
    oval_nxt  = oval_r && !out_ready;
    orep_nxt  = orep_r;
    olm_nxt   = olm_r;
    orm_nxt   = orm_r;
    obar_nxt  = obar_r;
    oled_nxt  = oled_r;
    q_pop     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (q_item.kind == smlb_pkg::KIND_FRAME) begin
            // a full counter drops the frame from the sums, count and activity flag; a frame result beat is still sent
            if (cnt_r != '1) begin
              lsum_nxt = lsum_r + SW'(q_item.left_mag);
              rsum_nxt = rsum_r + SW'(q_item.right_mag);
              cnt_nxt  = cnt_r + CW'(1);
              if (q_item.active) begin
                act_nxt = (q_item.half == smlb_pkg::HALF_FIRST);
              end
            end
            oval_nxt = 1'b1;
            orep_nxt = 1'b0;
            olm_nxt  = '0;
            orm_nxt  = '0;
            obar_nxt = '0;
            oled_nxt = act_nxt;
          end else begin
            lsum_nxt = '0;
            rsum_nxt = '0;
            cnt_nxt  = '0;
            if (cnt_r == '0) begin
              oval_nxt = 1'b1;
              orep_nxt = 1'b1;
              olm_nxt  = '0;
              orm_nxt  = '0;
              obar_nxt = '0;
              oled_nxt = act_r;
            end else begin
              lq_nxt    = lsum_r;
              rq_nxt    = rsum_r;
              lrem_nxt  = '0;
              rrem_nxt  = '0;
              dvs_nxt   = cnt_r;
              step_nxt  = '0;
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        lrem_nxt = lrem_step;
        rrem_nxt = rrem_step;
        lq_nxt   = {lq_r[SW-2:0], lge};
        rq_nxt   = {rq_r[SW-2:0], rge};
        step_nxt = step_r + smlb_pkg::STEP_W'(1);
        if (step_r == smlb_pkg::STEP_W'(SW - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          oval_nxt  = 1'b1;
          orep_nxt  = 1'b1;
          olm_nxt   = lq_r[smlb_pkg::MAG_W-1:0];
          orm_nxt   = rq_r[smlb_pkg::MAG_W-1:0];
          obar_nxt  = smlb_pkg::bar_of(lq_r[smlb_pkg::MAG_W-1:0]);
          oled_nxt  = act_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lsum_r  <= '0;
      rsum_r  <= '0;
      cnt_r   <= '0;
      act_r   <= 1'b0;
      step_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lsum_r  <= lsum_nxt;
      rsum_r  <= rsum_nxt;
      cnt_r   <= cnt_nxt;
      act_r   <= act_nxt;
      step_r  <= step_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lq_r   <= lq_nxt;
    rq_r   <= rq_nxt;
    lrem_r <= lrem_nxt;
    rrem_r <= rrem_nxt;
    dvs_r  <= dvs_nxt;
    orep_r <= orep_nxt;
    olm_r  <= olm_nxt;
    orm_r  <= orm_nxt;
    obar_r <= obar_nxt;
    oled_r <= oled_nxt;
  end

  assign out_valid  = oval_r;
  assign out_report = orep_r;
  assign out_lmean  = olm_r;
  assign out_rmean  = orm_r;
  assign out_bar    = obar_r;
  assign out_led    = oled_r;

  `SMLB_ASSERT_NOW(a_no_pop_busy, state_r != ST_IDLE, !q_pop, "queue popped while dividing")
  `SMLB_ASSERT_NEXT(a_tick_clears, q_pop && q_item.kind == smlb_pkg::KIND_TICK, cnt_r == '0 && lsum_r == '0 && rsum_r == '0, "tick left state uncleared")
  `SMLB_ASSERT_NEXT(a_cnt_sat, cnt_r == '1, cnt_r == '1 || cnt_r == '0, "frame count wrapped")
  `SMLB_ASSERT_NOW(a_frame_zero, oval_r && !orep_r, olm_r == '0 && orm_r == '0 && obar_r == '0, "frame result carries level")

endmodule

// ===== hdl/stereo_mean_level_bar_meter.sv =====
`timescale 1ns / 1ps
// channel  | dir | beat contents (tdata low bit up)                      | tuser
// in_      | in  | left_word[31:0], right_word[31:0], frame_half, pad 7  | kind
// out_     | out | left_mean[25:0], right_mean[25:0], bar_level[3:0],    | report_valid
//          |     |   activity_led, pad 7                                  |
// a sample frame beat is popped only when the output slot is free, its result registered as it is popped
// a report tick with frames counted is loaded, runs 42 steps of the one-bit restoring
//   divider (sum width), then finishes once the output slot is free; a tick with no frames answers at once
// reset clears the two-entry queue, sums, frame count, activity flag and output valid
// the queue keeps taking input beats, until both entries are full, while the back end divides or out_tready is low
module stereo_mean_level_bar_meter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [smlb_pkg::IN_TDATA_W-1:0]     in_tdata,  // left_word, right_word, frame_half
  input  logic                                in_tuser,  // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [smlb_pkg::OUT_TDATA_W-1:0]    out_tdata, // left_mean, right_mean, bar_level,
                                                         // activity_led
  output logic                                out_tuser  // report_valid
);

  localparam int PAD_W = smlb_pkg::OUT_TDATA_W - 2 * smlb_pkg::MAG_W - smlb_pkg::BAR_W - 1;

  smlb_pkg::qitem_t push_item;
  smlb_pkg::qitem_t q_item;
  logic             q_full;
  logic             q_push;
  logic             q_valid;
  logic             q_pop;
  smlb_pkg::mag_t   lmean;
  smlb_pkg::mag_t   rmean;
  smlb_pkg::bar_t   bar;
  logic             led;

  smlb_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  smlb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  smlb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_report (out_tuser),
    .out_lmean  (lmean),
    .out_rmean  (rmean),
    .out_bar    (bar),
    .out_led    (led)
  );

  assign out_tdata = {{PAD_W{1'b0}}, led, bar, rmean, lmean};

endmodule

// ===== tb/stereo_mean_level_bar_meter_checker.sv =====
`timescale 1ns / 1ps
module stereo_mean_level_bar_meter_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [smlb_pkg::IN_TDATA_W-1:0]  in_tdata,  // left_word, right_word, frame_half
  input  logic                             in_tuser,  // kind
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [smlb_pkg::OUT_TDATA_W-1:0] out_tdata, // left_mean, right_mean, bar_level,
                                                      // activity_led
  input  logic                             out_tuser, // report_valid
  output int                               mismatch_count,
  output int                               reports_waiting
);

  typedef struct packed {
    logic               report;
    smlb_pkg::mag_t     left_mean;
    smlb_pkg::mag_t     right_mean;
    smlb_pkg::bar_t     bar;
    logic               led;
  } level_report_t;

  level_report_t     reports_due[$];
  smlb_pkg::sum_t    left_total;
  smlb_pkg::sum_t    right_total;
  smlb_pkg::count_t  frames_in_period;
  logic              active;
  int                mismatches;

  initial begin
    mismatches = 0;
  end

  // |word >>> 6| built from the sign-extended upper bits
  function automatic smlb_pkg::mag_t word_magnitude(input logic [31:0] word);
    logic [31:0] scaled;
    scaled = {{6{word[31]}}, word[31:6]};
    if (scaled[31]) begin
      scaled = ~scaled + 32'd1;
    end
    return scaled[25:0];
  endfunction

  function automatic smlb_pkg::bar_t segments_lit(input smlb_pkg::mag_t mean);
    smlb_pkg::bar_t lit;
    lit = '0;
    if (mean >= 26'd734000)   lit = lit + 4'd1;
    if (mean >= 26'd2350000)  lit = lit + 4'd1;
    if (mean >= 26'd3350000)  lit = lit + 4'd1;
    if (mean >= 26'd4250000)  lit = lit + 4'd1;
    if (mean >= 26'd5250000)  lit = lit + 4'd1;
    if (mean >= 26'd6000000)  lit = lit + 4'd1;
    if (mean >= 26'd6800000)  lit = lit + 4'd1;
    if (mean >= 26'd7500000)  lit = lit + 4'd1;
    if (mean >= 26'd8500000)  lit = lit + 4'd1;
    if (mean >= 26'd9500000)  lit = lit + 4'd1;
    if (mean >= 26'd10800000) lit = lit + 4'd1;
    return lit;
  endfunction

  task automatic meter_step(input logic kind, input logic [31:0] lw, input logic [31:0] rw,
                            input logic half);
    level_report_t  rep;
    smlb_pkg::mag_t lmag;
    smlb_pkg::mag_t rmag;
    rep = '0;
    if (kind == smlb_pkg::KIND_FRAME) begin
      // a full counter freezes the whole period
      if (frames_in_period != '1) begin
        lmag = word_magnitude(lw);
        rmag = word_magnitude(rw);
        left_total       = left_total + smlb_pkg::sum_t'(lmag);
        right_total      = right_total + smlb_pkg::sum_t'(rmag);
        frames_in_period = frames_in_period + 1'b1;
        if (lmag != '0 || rmag != '0) begin
          active = (half == smlb_pkg::HALF_FIRST);
        end
      end
    end else begin
      rep.report = 1'b1;
      if (frames_in_period != '0) begin
        rep.left_mean  = smlb_pkg::mag_t'(left_total / smlb_pkg::sum_t'(frames_in_period));
        rep.right_mean = smlb_pkg::mag_t'(right_total / smlb_pkg::sum_t'(frames_in_period));
      end
      rep.bar          = segments_lit(rep.left_mean);
      left_total       = '0;
      right_total      = '0;
      frames_in_period = '0;
    end
    rep.led = active;
    reports_due.push_back(rep);
  endtask

  task automatic compare_beat();
    level_report_t want;
    level_report_t got;
    got.report     = out_tuser;
    got.left_mean  = out_tdata[25:0];
    got.right_mean = out_tdata[51:26];
    got.bar        = out_tdata[55:52];
    got.led        = out_tdata[56];
    if (reports_due.size() == 0) begin
      mismatches = mismatches + 1;
      if (mismatches <= 10) begin
        $display("%0t: result beat with nothing expected: report=%0d left=%0d right=%0d bar=%0d led=%0d",
                 $realtime, got.report, got.left_mean, got.right_mean, got.bar, got.led);
      end
    end else begin
      want = reports_due.pop_front();
      if (got.report !== want.report || got.left_mean !== want.left_mean ||
          got.right_mean !== want.right_mean || got.bar !== want.bar || got.led !== want.led) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
          $display("%0t: mismatch expected report=%0d left=%0d right=%0d bar=%0d led=%0d",
                   $realtime, want.report, want.left_mean, want.right_mean, want.bar, want.led);
          $display("%0t:          actual   report=%0d left=%0d right=%0d bar=%0d led=%0d",
                   $realtime, got.report, got.left_mean, got.right_mean, got.bar, got.led);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reports_due.delete();
      left_total       = '0;
      right_total      = '0;
      frames_in_period = '0;
      active           = 1'b0;
    end else begin
      // a result beat never belongs to an input beat of the same edge
      if (out_tvalid && out_tready) begin
        compare_beat();
      end
      if (in_tvalid && in_tready) begin
        meter_step(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[64]);
      end
    end
    mismatch_count  <= mismatches;
    reports_waiting <= reports_due.size();
  end

endmodule

// ===== tb/stereo_mean_level_bar_meter_test.sv =====
`timescale 1ns / 1ps
module stereo_mean_level_bar_meter_test;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [smlb_pkg::IN_TDATA_W-1:0]  in_tdata;  // left_word, right_word, frame_half
  logic                             in_tuser;  // kind
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [smlb_pkg::OUT_TDATA_W-1:0] out_tdata; // left_mean, right_mean, bar_level,
                                               // activity_led
  logic                             out_tuser; // report_valid
  int                               mismatch_count;
  int                               reports_waiting;

  int burst_left;
  int n_frames;
  int n_ticks;
  int sink_mode  = 0;
  int sink_span  = 0;
  int sink_phase = 0;

  stereo_mean_level_bar_meter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  stereo_mean_level_bar_meter_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatch_count  (mismatch_count),
    .reports_waiting (reports_waiting)
  );

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // receiver: runs of always-ready, mostly-ready, mostly-stalled and a fixed duty pattern
  always @(posedge clk) begin
    if (sink_span == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_span = $urandom_range(30, 400);
    end else begin
      sink_span = sink_span - 1;
    end
    sink_phase = (sink_phase + 1) % 7;
    case (sink_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (sink_phase < 4);
    endcase
  end

  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic push_beat(input logic kind, input logic [31:0] lw, input logic [31:0] rw,
                           input logic half);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, half, rw, lw};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    if (kind == smlb_pkg::KIND_TICK) begin
      n_ticks = n_ticks + 1;
    end else begin
      n_frames = n_frames + 1;
    end
  endtask

  // bursts of back-to-back beats with idle gaps of random length between most of them
  task automatic offer(input logic kind, input logic [31:0] lw, input logic [31:0] rw,
                       input logic half);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 4) != 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    push_beat(kind, lw, rw, half);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_waiting != 0) begin
      @(posedge clk);
    end
    burst_left = 0;
  endtask

  task automatic tick();
    offer(smlb_pkg::KIND_TICK, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [31:0] audio_word();
    logic [23:0] sample;
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: w = $urandom();
      1: begin
        sample = 24'($urandom());
        w = {sample, 8'h00};
      end
      2: w = $urandom_range(0, 63);
      3: begin
        case ($urandom_range(0, 3))
          0:       w = 32'h8000_0000;
          1:       w = 32'h7FFF_FFFF;
          2:       w = 32'hFFFF_FFFF;
          default: w = 32'hFFFF_FFC0;
        endcase
      end
      default: begin
        w = $urandom_range(0, 12_000_000) << 6;
        if ($urandom_range(0, 1) == 1) begin
          w = ~w + 32'd1;
        end
      end
    endcase
    return w;
  endfunction

  // a sample whose shifted magnitude sits near the given level, mostly at or just under it
  function automatic logic [31:0] word_near(input int unsigned level);
    int unsigned m;
    logic [31:0] w;
    m = level - $urandom_range(0, level / 32);
    w = (m << 6) | ($urandom() & 32'h3F);
    if ($urandom_range(0, 1) == 1) begin
      w = ~w + 32'd1;
    end
    return w;
  endfunction

  initial begin
    int          rand_items;
    int          period_len;
    int unsigned level;
    int          flavor;
    logic        cur_half;
    logic [31:0] lw;
    logic [31:0] rw;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = smlb_pkg::KIND_FRAME;
    burst_left = 0;
    n_frames   = 0;
    n_ticks    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty period, extreme words, activity rules, bar thresholds
    tick();
    offer(smlb_pkg::KIND_FRAME, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    offer(smlb_pkg::KIND_FRAME, 32'h0000_003F, 32'h0000_0000, 1'b1);
    offer(smlb_pkg::KIND_FRAME, 32'h0000_0040, 32'h0000_0000, 1'b1);
    offer(smlb_pkg::KIND_FRAME, 32'h0000_0000, 32'h0000_0020, 1'b0);
    offer(smlb_pkg::KIND_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFC0, 1'b0);
    tick();
    tick();
    offer(smlb_pkg::KIND_FRAME, 32'd734000 << 6, 32'h1234_5600, 1'b1);
    tick();
    offer(smlb_pkg::KIND_FRAME, 32'd733999 << 6, 32'hEDCB_A900, 1'b0);
    tick();
    offer(smlb_pkg::KIND_FRAME, 32'd10800000 << 6, 32'h0000_0000, 1'b0);
    tick();
    offer(smlb_pkg::KIND_FRAME, 32'd10799999 << 6, 32'h8000_0000, 1'b1);
    offer(smlb_pkg::KIND_FRAME, 32'h8000_0000, 32'h8000_0000, 1'b0);
    offer(smlb_pkg::KIND_FRAME, 32'h7FFF_FFC0, 32'hFFFF_FFFF, 1'b1);
    tick();
    offer(smlb_pkg::KIND_FRAME, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    offer(smlb_pkg::KIND_FRAME, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    tick();
    drain();

    // random periods: mostly steady levels, some noise, some empty periods
    rand_items = 0;
    cur_half   = 1'b0;
    while (rand_items < 1320) begin
      case ($urandom_range(0, 9))
        0:       period_len = 0;
        1:       period_len = $urandom_range(40, 120);
        default: period_len = $urandom_range(1, 20);
      endcase
      level  = $urandom_range(1, 12_000_000);
      flavor = $urandom_range(0, 3);
      for (int i = 0; i < period_len; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          cur_half = ~cur_half;
        end
        if ($urandom_range(0, 7) == 0) begin
          lw = $urandom_range(0, 63);
          rw = $urandom_range(0, 63);
        end else if (flavor == 0) begin
          lw = audio_word();
          rw = audio_word();
        end else begin
          lw = word_near(level);
          rw = ($urandom_range(0, 2) == 0) ? audio_word() : word_near(level / 2 + 1);
        end
        offer(smlb_pkg::KIND_FRAME, lw, rw, cur_half);
      end
      tick();
      rand_items = rand_items + period_len + 1;
      if ($urandom_range(0, 14) == 0) begin
        drain();
      end
    end
    tick();
    tick();

    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d sample frames and %0d report ticks", n_frames, n_ticks);
    $display("incl. empty periods, zero frames, extreme words and bar thresholds");
    if (mismatch_count == 0 && reports_waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== stereo_mean_level_bar_meter.f =====
+incdir+hdl
hdl/smlb_pkg.sv
hdl/smlb_front.sv
hdl/smlb_queue.sv
hdl/smlb_back.sv
hdl/stereo_mean_level_bar_meter.sv
tb/stereo_mean_level_bar_meter_checker.sv
tb/stereo_mean_level_bar_meter_test.sv
